[design/chrl_pkg.sv]
// ----------------------------------------------------------------------------
// chrl_pkg: shared types and constants for the hash ring lookup block
// Holds ring sizes, hash constants, result codes and the front/back queue item.
// ----------------------------------------------------------------------------
package chrl_pkg;

    localparam int RING_ENTRIES = 1024;
    localparam int IDX_W        = $clog2(RING_ENTRIES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int CACHE_W      = 8;

    localparam logic [31:0] MM_MUL  = 32'h5bd1e995;
    localparam logic [31:0] MM_SEED = 32'd97;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_COLLISION = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    // work handed from the front (hash) to the back (ring)
    typedef struct packed {
        logic        is_insert;
        logic [31:0] value;
        logic [7:0]  cache;
    } job_t;

    typedef enum logic [2:0] {
        HS_IDLE, HS_M1, HS_M2, HS_M3, HS_F1, HS_F2
    } hstate_t;

    typedef enum logic [2:0] {
        RS_IDLE, RS_SRCH, RS_WAIT, RS_DECIDE, RS_SHIFT, RS_RD, RS_OUT
    } rstate_t;

endpackage

[design/chrl_front.sv]
// ----------------------------------------------------------------------------
// chrl_front: input acceptance and MurmurHash2 engine
// Mixes key chunks step by step with one combinational multiplier and
// passes finished hashes and insert commands to the job queue.
// ----------------------------------------------------------------------------
module chrl_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 cmd,
    input  logic [15:0]          key_total_length,
    input  logic [31:0]          chunk_word,
    input  logic [2:0]           chunk_bytes,
    input  logic                 chunk_last,
    input  logic [31:0]          node_position,
    input  logic [7:0]           node_cache,
    output logic                 job_valid,
    input  logic                 job_ready,
    output chrl_pkg::job_t       job
);

    chrl_pkg::hstate_t state_reg, state_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] k_reg, k_next;
    logic        kip_reg, kip_next;
    logic        last_reg, last_next;
    logic        full_reg, full_next;
    logic        jv_reg, jv_next;
    chrl_pkg::job_t job_reg, job_next;
    logic [31:0] mul_a, mul_b, prod;
    logic [2:0]  nb;
    logic [31:0] h0, tail;
    logic        acc;

    assign prod = mul_a * mul_b;
    assign nb   = (chunk_bytes > 3'd4) ? 3'd4 : chunk_bytes;
    assign h0   = kip_reg ? h_reg : (chrl_pkg::MM_SEED ^ {16'd0, key_total_length});
    assign in_ready = (state_reg == chrl_pkg::HS_IDLE) && !jv_reg;
    assign acc  = in_valid && in_ready;
    assign job_valid = jv_reg;
    assign job = job_reg;

    always_comb
    begin
        unique case (nb)
            3'd1:    tail = {24'd0, chunk_word[7:0]};
            3'd2:    tail = {16'd0, chunk_word[15:0]};
            3'd3:    tail = {8'd0, chunk_word[23:0]};
            default: tail = 32'd0;
        endcase
    end

    // pick multiplier operands per step
    always_comb
    begin
        mul_a = h_reg;
        mul_b = chrl_pkg::MM_MUL;
        unique case (state_reg)
            chrl_pkg::HS_M1: mul_a = k_reg;
            chrl_pkg::HS_M2: mul_a = k_reg ^ (k_reg >> 24);
            chrl_pkg::HS_M3: mul_a = h_reg;
            chrl_pkg::HS_F1: mul_a = h_reg ^ (h_reg >> 13);
            default:         mul_a = h_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            chrl_pkg::HS_IDLE:
                if (acc && !cmd)
                begin
                    if (nb == 3'd4)
                        state_next = chrl_pkg::HS_M1;
                    else if (chunk_last)
                        state_next = (nb != 3'd0) ? chrl_pkg::HS_M3 : chrl_pkg::HS_F1;
                end
            chrl_pkg::HS_M1: state_next = chrl_pkg::HS_M2;
            chrl_pkg::HS_M2: state_next = chrl_pkg::HS_M3;
            chrl_pkg::HS_M3: state_next = last_reg ? chrl_pkg::HS_F1 : chrl_pkg::HS_IDLE;
            chrl_pkg::HS_F1: state_next = chrl_pkg::HS_F2;
            chrl_pkg::HS_F2: state_next = chrl_pkg::HS_IDLE;
            default:         state_next = chrl_pkg::HS_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        h_next    = h_reg;
        k_next    = k_reg;
        kip_next  = kip_reg;
        last_next = last_reg;
        full_next = full_reg;
        jv_next   = jv_reg && !job_ready;
        job_next  = job_reg;
        unique case (state_reg)
            chrl_pkg::HS_IDLE:
                if (acc)
                begin
                    if (cmd)
                    begin
                        jv_next  = 1'b1;
                        job_next = '{is_insert: 1'b1, value: node_position,
                                     cache: node_cache};
                    end
                    else if (nb == 3'd4 || chunk_last)
                    begin
                        kip_next  = 1'b1;
                        last_next = chunk_last;
                        full_next = (nb == 3'd4);
                        h_next    = (nb == 3'd4) ? h0 : (h0 ^ tail);
                        k_next    = chunk_word;
                    end
                end
            chrl_pkg::HS_M1: k_next = prod;
            chrl_pkg::HS_M2: k_next = prod;
            chrl_pkg::HS_M3: h_next = full_reg ? (prod ^ k_reg) : prod;
            chrl_pkg::HS_F1: h_next = prod;
            chrl_pkg::HS_F2:
            begin
                h_next   = h_reg ^ (h_reg >> 15);
                kip_next = 1'b0;
                jv_next  = 1'b1;
                job_next = '{is_insert: 1'b0, value: h_reg ^ (h_reg >> 15),
                             cache: 8'd0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chrl_pkg::HS_IDLE;
            h_reg     <= '0;
            kip_reg   <= 1'b0;
            jv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            h_reg     <= h_next;
            kip_reg   <= kip_next;
            jv_reg    <= jv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        last_reg <= last_next;
        full_reg <= full_next;
        job_reg  <= job_next;
    end

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != chrl_pkg::HS_IDLE) |-> !in_ready)
        else $error("front accepted while hashing");
    a_fin_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == chrl_pkg::HS_F2) |=> job_valid && !job.is_insert)
        else $error("finished hash not queued");
    a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == chrl_pkg::HS_F2) |=> !kip_reg)
        else $error("key still open after final");

endmodule

[design/chrl_back.sv]
// ----------------------------------------------------------------------------
// chrl_back: sorted ring store, binary search and insert shifting
// Searches the ring memory one read a step, shifts entries up to make room
// on insert, and holds the result in an output register.
// ----------------------------------------------------------------------------
module chrl_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  chrl_pkg::job_t                job,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    status,
    output logic [chrl_pkg::IDX_W-1:0]    node_index,
    output logic [7:0]                    served_cache,
    output logic [31:0]                   key_hash
);

    localparam int IW = chrl_pkg::IDX_W;
    localparam int CW = chrl_pkg::CNT_W;

    logic [31:0] pos_mem [chrl_pkg::RING_ENTRIES];
    logic [7:0]  cac_mem [chrl_pkg::RING_ENTRIES];

    chrl_pkg::rstate_t state_reg, state_next;
    chrl_pkg::job_t    j_reg, j_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0] sh_reg, sh_next;
    logic [CW-1:0] mid;
    logic          ov_reg, ov_next;
    logic [2:0]    st_reg, st_next;
    logic [IW-1:0] ni_reg, ni_next;
    logic [7:0]    sc_reg, sc_next;
    logic          sc_mem_reg, sc_mem_next;
    logic [31:0]   kh_reg, kh_next;
    logic [IW-1:0] raddr;
    logic [31:0]   rpos;
    logic [7:0]    rcac;
    logic          we;
    logic [IW-1:0] waddr;
    logic [31:0]   wpos;
    logic [7:0]    wcac;
    logic [CW-1:0] idx1;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign job_ready = (state_reg == chrl_pkg::RS_IDLE);
    assign out_valid = ov_reg;
    assign status = st_reg;
    assign node_index = ni_reg;
    assign served_cache = sc_mem_reg ? rcac : sc_reg;
    assign key_hash = kh_reg;

    // memory: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            pos_mem[waddr] <= wpos;
            cac_mem[waddr] <= wcac;
        end
        rpos <= pos_mem[raddr];
        rcac <= cac_mem[raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            chrl_pkg::RS_IDLE:
                if (job_valid)
                    state_next = chrl_pkg::RS_SRCH;
            chrl_pkg::RS_SRCH:
                state_next = (lo_reg < hi_reg) ? chrl_pkg::RS_WAIT : chrl_pkg::RS_DECIDE;
            chrl_pkg::RS_WAIT:
                state_next = chrl_pkg::RS_SRCH;
            chrl_pkg::RS_DECIDE:
                state_next = chrl_pkg::RS_RD;
            chrl_pkg::RS_RD:
                state_next = chrl_pkg::RS_OUT;
            chrl_pkg::RS_SHIFT:
                state_next = (sh_reg == lo_reg) ? chrl_pkg::RS_OUT : chrl_pkg::RS_SHIFT;
            chrl_pkg::RS_OUT:
                if (!ov_reg || out_ready)
                    state_next = chrl_pkg::RS_IDLE;
            default: state_next = chrl_pkg::RS_IDLE;
        endcase
        if (state_reg == chrl_pkg::RS_DECIDE && j_reg.is_insert)
        begin
            if (lo_reg < cnt_reg && rpos == j_reg.value)
                state_next = chrl_pkg::RS_OUT;
            else if (cnt_reg == CW'(chrl_pkg::RING_ENTRIES))
                state_next = chrl_pkg::RS_OUT;
            else
                state_next = chrl_pkg::RS_SHIFT;
        end
        if (state_reg == chrl_pkg::RS_DECIDE && !j_reg.is_insert && cnt_reg == '0)
            state_next = chrl_pkg::RS_OUT;
    end

    // datapath
    always_comb
    begin
        j_next  = j_reg;
        cnt_next = cnt_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        sh_next = sh_reg;
        ov_next = ov_reg && !out_ready;
        st_next = st_reg;
        ni_next = ni_reg;
        sc_next = sc_reg;
        sc_mem_next = sc_mem_reg;
        kh_next = kh_reg;
        raddr = mid[IW-1:0];
        we    = 1'b0;
        waddr = sh_reg[IW-1:0];
        wpos  = rpos;
        wcac  = rcac;
        idx1  = '0;
        unique case (state_reg)
            chrl_pkg::RS_IDLE:
                if (job_valid)
                begin
                    j_next  = job;
                    lo_next = '0;
                    hi_next = cnt_reg;
                end
            chrl_pkg::RS_SRCH: raddr = mid[IW-1:0];
            chrl_pkg::RS_WAIT:
            begin
                if (rpos < j_reg.value)
                    lo_next = mid + 1'b1;
                else
                    hi_next = mid;
            end
            chrl_pkg::RS_DECIDE:
            begin
                // read the lower-bound entry (already addressed in SRCH)
                raddr = lo_reg[IW-1:0];
                if (j_reg.is_insert)
                begin
                    kh_next = '0;
                    sc_mem_next = 1'b0;
                    if (lo_reg < cnt_reg && rpos == j_reg.value)
                    begin
                        st_next = chrl_pkg::ST_COLLISION;
                        ni_next = lo_reg[IW-1:0];
                        sc_next = rcac;
                        ov_next = 1'b1;
                    end
                    else if (cnt_reg == CW'(chrl_pkg::RING_ENTRIES))
                    begin
                        st_next = chrl_pkg::ST_FULL;
                        ni_next = '0;
                        sc_next = '0;
                        ov_next = 1'b1;
                    end
                    else
                    begin
                        sh_next = cnt_reg;
                        raddr   = IW'(cnt_reg - 1'b1);
                    end
                end
                else
                begin
                    kh_next = j_reg.value;
                    if (cnt_reg == '0)
                    begin
                        st_next = chrl_pkg::ST_EMPTY;
                        ni_next = '0;
                        sc_next = '0;
                        sc_mem_next = 1'b0;
                        ov_next = 1'b1;
                    end
                    else
                    begin
                        idx1 = (lo_reg >= cnt_reg) ? CW'(1) : lo_reg + 1'b1;
                        if (idx1 >= cnt_reg)
                            idx1 = '0;
                        ni_next = idx1[IW-1:0];
                        raddr   = idx1[IW-1:0];
                        st_next = chrl_pkg::ST_DONE;
                    end
                end
            end
            chrl_pkg::RS_RD:
            begin
                sc_mem_next = 1'b1;
                raddr = ni_reg;
                ov_next = 1'b1;
            end
            chrl_pkg::RS_SHIFT:
            begin
                // move entry sh-1 up to sh, then place the new entry at lo
                we = 1'b1;
                waddr = sh_reg[IW-1:0];
                if (sh_reg == lo_reg)
                begin
                    wpos = j_reg.value;
                    wcac = j_reg.cache;
                    cnt_next = cnt_reg + 1'b1;
                    st_next = chrl_pkg::ST_INSERTED;
                    ni_next = lo_reg[IW-1:0];
                    sc_next = j_reg.cache;
                    ov_next = 1'b1;
                end
                else
                begin
                    sh_next = sh_reg - 1'b1;
                    raddr = IW'(sh_reg - 2'd2);
                end
            end
            chrl_pkg::RS_OUT:
            begin
                raddr = ni_reg;
                if (ov_reg && out_ready)
                    sc_mem_next = 1'b0;
            end
            default: ;
        endcase
        if (state_reg == chrl_pkg::RS_OUT && ov_reg && out_ready)
        begin
            sc_next = served_cache;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= chrl_pkg::RS_IDLE;
            cnt_reg    <= '0;
            ov_reg     <= 1'b0;
            sc_mem_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ov_reg     <= ov_next;
            sc_mem_reg <= sc_mem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg  <= j_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        sh_reg <= sh_next;
        st_reg <= st_next;
        ni_reg <= ni_next;
        sc_reg <= sc_next;
        kh_reg <= kh_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(chrl_pkg::RING_ENTRIES))
        else $error("ring count overflow");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("ring count jumped");
    a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == chrl_pkg::RS_SRCH) |-> (lo_reg <= hi_reg && hi_reg <= cnt_reg))
        else $error("search window broken");

endmodule

[design/consistent_hash_ring_lookup.sv]
// ----------------------------------------------------------------------------
// consistent_hash_ring_lookup: consistent-hash ring with MurmurHash2 lookup
// Front hashes streamed key chunks; a job queue feeds the back, which keeps
// the sorted ring and does binary search and ordered insertion.
//
//   channel | direction | handshake           | payload
//   input   | in        | in_valid/in_ready   | cmd, key_total_length, chunk_*,
//           |           |                     | node_position, node_cache
//   output  | out       | out_valid/out_ready | status, node_index,
//           |           |                     | served_cache, key_hash
//
// A full chunk runs the hash unit through steps M1, M2 and M3 (one shared
// multiplier), the final chunk two finishing steps (F1, F2) and the hand-off.
// A lookup in the back is a binary search bound by the single memory read
// port; an insert then shifts each later entry up, one write per entry.
// Reset empties the ring at once (count goes to zero).
// Either side stalls alone behind the two-entry job queue.
// ----------------------------------------------------------------------------
module consistent_hash_ring_lookup (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       cmd,
    input  logic [15:0]                key_total_length,
    input  logic [31:0]                chunk_word,
    input  logic [2:0]                 chunk_bytes,
    input  logic                       chunk_last,
    input  logic [31:0]                node_position,
    input  logic [7:0]                 node_cache,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [2:0]                 status,
    output logic [chrl_pkg::IDX_W-1:0] node_index,
    output logic [7:0]                 served_cache,
    output logic [31:0]                key_hash
);

    logic           fj_valid, fj_ready, bj_valid, bj_ready;
    chrl_pkg::job_t fj, bj;
    chrl_pkg::job_t q_reg [2];
    logic           wp_reg, rp_reg;
    logic [1:0]     n_reg;

    chrl_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .cmd, .key_total_length,
        .chunk_word, .chunk_bytes, .chunk_last, .node_position, .node_cache,
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    // two-entry job queue between front and back
    assign fj_ready = (n_reg != 2'd2);
    assign bj_valid = (n_reg != 2'd0);
    assign bj = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (fj_valid && fj_ready)
            q_reg[wp_reg] <= fj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            n_reg  <= 2'd0;
        end
        else
        begin
            if (fj_valid && fj_ready)
                wp_reg <= ~wp_reg;
            if (bj_valid && bj_ready)
                rp_reg <= ~rp_reg;
            n_reg <= n_reg + 2'((fj_valid && fj_ready) ? 1 : 0)
                           - 2'((bj_valid && bj_ready) ? 1 : 0);
        end
    end

    chrl_back u_back (
        .clk, .rst_n, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
        .out_valid, .out_ready, .status, .node_index, .served_cache, .key_hash
    );

    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= 2'd2)
        else $error("job queue overflow");
    a_q_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (n_reg == 2'd0 || n_reg == 2'd2) |-> (wp_reg == rp_reg))
        else $error("queue pointers disagree with count");
    a_q_one: assert property (@(posedge clk) disable iff (!rst_n)
        (n_reg == 2'd1) |-> (wp_reg != rp_reg))
        else $error("queue pointers disagree with count");

endmodule
